// ===== rtl/bcc_pkg.sv =====
// bcc_pkg: shared types and constants of the button click classifier
// used by bcc_ctrl, bcc_datapath and button_click_classifier; no dependencies
`default_nettype none

package bcc_pkg;

    localparam int MAX_BUTTONS = 10;
    localparam int BTN_W       = (MAX_BUTTONS > 1) ? $clog2(MAX_BUTTONS) : 1;
    localparam int CNT_W       = $clog2(MAX_BUTTONS + 1);

    // field widths
    localparam int CMD_W   = 2;
    localparam int MS_W    = 16;
    localparam int LVL_W   = 10;
    localparam int IDX_W   = 4;
    localparam int EV_W    = 3;
    localparam int ID_W    = 4;
    localparam int BCNT_W  = 4;
    localparam int CFGI_W  = 3;
    localparam int CFGD_W  = 16;
    localparam int IN_W    = 32;
    localparam int OUT_W   = 8;

    localparam logic [MS_W-1:0] DUR_MAX = 16'hFFFF;
    localparam logic [MS_W-1:0] DUR_ONE = 16'h0001;

    typedef enum logic [CMD_W-1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_PAUSE  = 2'd1,
        CMD_RESUME = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    typedef enum logic [EV_W-1:0] {
        EV_PRESSED   = 3'd0,
        EV_RELEASED  = 3'd1,
        EV_CLICK     = 3'd2,
        EV_DBLCLICK  = 3'd3,
        EV_LONGCLICK = 3'd4
    } event_t;

    typedef enum logic [CFGI_W-1:0] {
        REG_BUTTON_COUNT = 3'd0,
        REG_ACTIVE_MASK  = 3'd1,
        REG_CLICK_MIN    = 3'd2,
        REG_LONG_MIN     = 3'd3,
        REG_DBL_WINDOW   = 3'd4
    } reg_idx_t;

    // controller to datapath
    typedef struct packed {
        logic load;       // latch the accepted input word
        logic apply;      // carry out pause or resume, clear the walk index
        logic step;       // evaluate the button at the walk index
        logic flush;      // hand the held event out as the final one
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_sample;
        logic has_buttons;
        logic walk_last;
        logic step_stall;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/button_click_classifier.sv =====
// button_click_classifier: top level, joins the controller and the datapath
// depends on bcc_pkg, bcc_ctrl and bcc_datapath
`default_nettype none

// Classifies press, release, click, double click and long click events of up
// to ten push buttons. Each input word is a sample of all button levels with
// the milliseconds since the previous sample, or a pause or resume command for
// one button. A sample is handled by walking the buttons in use (button_count,
// at most ten) one per clock while the output side does not stall the walk;
// a sample with no button in use, pause, resume and unused commands skip the
// walk and go from decoding straight back to idle.
// Events leave in increasing button order, tlast marking the final event of a
// sample; a sample that causes no event produces no output word. The input
// side accepts only while no word is in progress; the output register lets the
// block finish a word while the last event still waits to be taken.
// Configuration is written through cfg_valid/cfg_index/cfg_data, always ready,
// and is meant to change only while the block is idle.

module button_click_classifier (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [bcc_pkg::CFGI_W-1:0]  cfg_index,
    input  wire logic [bcc_pkg::CFGD_W-1:0]  cfg_data,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // command[1:0], elapsed_ms[17:2], input_levels[27:18], button_index[31:28]
    input  wire logic [bcc_pkg::IN_W-1:0]    s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // event_code[2:0], button_id[6:3], zero[7]
    output logic [bcc_pkg::OUT_W-1:0]        m_tdata,
    output logic                             m_tlast
);
    import bcc_pkg::*;

    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    bcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (dp_cmd)
    );

    bcc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/bcc_ctrl.sv =====
// bcc_ctrl: sequencing state machine of the button click classifier
// depends on bcc_pkg; drives bcc_datapath through dp_cmd_t, reads dp_status_t
`default_nettype none

module bcc_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire bcc_pkg::dp_status_t status,
    output bcc_pkg::dp_cmd_t        cmd
);
    import bcc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_DECODE = 4'b0010,
        ST_SCAN   = 4'b0100,
        ST_FLUSH  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.load = s_tvalid;
                if (s_tvalid)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                cmd.apply = 1'b1;
                if (status.is_sample && status.has_buttons)
                    state_next = ST_SCAN;
                else
                    state_next = ST_IDLE;
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (!status.step_stall && status.walk_last)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (!status.pend_valid || status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

// ===== rtl/bcc_datapath.sv =====
// bcc_datapath: configuration registers, per-button state and event evaluation
// depends on bcc_pkg; sequenced by bcc_ctrl
`default_nettype none

module bcc_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    input  wire logic [bcc_pkg::CFGI_W-1:0]  cfg_index,
    input  wire logic [bcc_pkg::CFGD_W-1:0]  cfg_data,
    input  wire logic [bcc_pkg::IN_W-1:0]    s_tdata,
    input  wire bcc_pkg::dp_cmd_t            cmd,
    output bcc_pkg::dp_status_t              status,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [bcc_pkg::OUT_W-1:0]        m_tdata,
    output logic                             m_tlast
);
    import bcc_pkg::*;

    // configuration
    logic [BCNT_W-1:0] button_count_reg;
    logic [LVL_W-1:0]  active_mask_reg;
    logic [MS_W-1:0]   click_min_reg;
    logic [MS_W-1:0]   long_min_reg;
    logic [MS_W-1:0]   dbl_window_reg;

    // per-button state
    logic [MS_W-1:0] dur_reg     [MAX_BUTTONS];
    logic            pressed_reg [MAX_BUTTONS];
    logic            armed_reg   [MAX_BUTTONS];
    logic            paused_reg  [MAX_BUTTONS];

    // latched input word
    cmd_t             in_cmd_reg;
    logic [MS_W-1:0]  in_elapsed_reg;
    logic [LVL_W-1:0] in_levels_reg;
    logic [IDX_W-1:0] in_index_reg;

    logic [BTN_W-1:0] walk_reg;

    // one event held back until it is known whether another follows
    logic             pend_valid_reg;
    event_t           pend_ev_reg;
    logic [BTN_W-1:0] pend_id_reg;

    logic             out_valid_reg;
    event_t           out_ev_reg;
    logic [BTN_W-1:0] out_id_reg;
    logic             out_last_reg;

    logic [CNT_W-1:0] count_eff;
    logic             idx_ok;
    logic [BTN_W-1:0] cmd_btn;
    logic             out_free;

    // evaluation of the walked button
    logic [MS_W:0]    dur_sum;
    logic [MS_W-1:0]  dur_grown;
    logic             level_active;
    logic             ev_emit;
    event_t           ev_code;
    logic [MS_W-1:0]  dur_next;
    logic             pressed_next;
    logic             armed_next;
    logic             step_go;
    logic             push_step;
    logic             push_flush;

    always_comb
    begin
        if ({{(CNT_W > BCNT_W ? CNT_W - BCNT_W : 0){1'b0}}, button_count_reg}
            > (CNT_W > BCNT_W ? CNT_W : BCNT_W)'(MAX_BUTTONS))
            count_eff = CNT_W'(MAX_BUTTONS);
        else
            count_eff = CNT_W'(button_count_reg);
    end

    assign idx_ok  = ({{CNT_W{1'b0}}, in_index_reg} < {{IDX_W{1'b0}}, count_eff});
    assign cmd_btn = BTN_W'(in_index_reg);
    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        dur_sum      = {1'b0, dur_reg[walk_reg]} + {1'b0, in_elapsed_reg};
        if (dur_reg[walk_reg] == '0)
            dur_grown = '0;
        else if (dur_sum >= {1'b0, DUR_MAX})
            dur_grown = DUR_MAX;
        else
            dur_grown = dur_sum[MS_W-1:0];

        level_active = (in_levels_reg[walk_reg] == active_mask_reg[walk_reg]);
        ev_emit      = 1'b0;
        ev_code      = EV_PRESSED;
        dur_next     = dur_grown;
        pressed_next = pressed_reg[walk_reg];
        armed_next   = armed_reg[walk_reg];

        if (level_active)
        begin
            if (!pressed_reg[walk_reg])
            begin
                armed_next   = (dur_grown != '0) && (dur_grown <= dbl_window_reg);
                pressed_next = 1'b1;
                dur_next     = DUR_ONE;
                ev_emit      = 1'b1;
            end
        end
        else if (pressed_reg[walk_reg])
        begin
            ev_emit      = 1'b1;
            pressed_next = 1'b0;
            if (dur_grown >= long_min_reg)
                ev_code = EV_LONGCLICK;
            else if (dur_grown >= click_min_reg)
                ev_code = armed_reg[walk_reg] ? EV_DBLCLICK : EV_CLICK;
            else
                ev_code = EV_RELEASED;
            // a click restarts the gap timer for the next double click
            if ((dur_grown >= click_min_reg) && (dur_grown < long_min_reg))
                dur_next = DUR_ONE;
            else
                dur_next = '0;
        end

        if (paused_reg[walk_reg])
            ev_emit = 1'b0;
    end

    assign status.is_sample   = (in_cmd_reg == CMD_SAMPLE);
    assign status.has_buttons = (count_eff != '0);
    assign status.walk_last   = ({{(CNT_W > BTN_W ? CNT_W - BTN_W : 0){1'b0}}, walk_reg}
                                 == BTN_W'(count_eff - CNT_W'(1)));
    assign status.step_stall  = ev_emit && pend_valid_reg && !out_free;
    assign status.pend_valid  = pend_valid_reg;
    assign status.out_free    = out_free;

    assign step_go    = cmd.step && !status.step_stall;
    assign push_step  = step_go && ev_emit && pend_valid_reg;
    assign push_flush = cmd.flush && pend_valid_reg && out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            button_count_reg <= '0;
            active_mask_reg  <= '0;
            click_min_reg    <= 16'd50;
            long_min_reg     <= 16'd1000;
            dbl_window_reg   <= 16'd500;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BUTTON_COUNT: button_count_reg <= cfg_data[BCNT_W-1:0];
                REG_ACTIVE_MASK:  active_mask_reg  <= cfg_data[LVL_W-1:0];
                REG_CLICK_MIN:    click_min_reg    <= cfg_data;
                REG_LONG_MIN:     long_min_reg     <= cfg_data;
                REG_DBL_WINDOW:   dbl_window_reg   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // button state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_BUTTONS; i++)
            begin
                dur_reg[i]     <= '0;
                pressed_reg[i] <= 1'b0;
                armed_reg[i]   <= 1'b0;
                paused_reg[i]  <= 1'b0;
            end
        end
        else if (cmd.apply && idx_ok)
        begin
            if (in_cmd_reg == CMD_PAUSE)
                paused_reg[cmd_btn] <= 1'b1;
            else if (in_cmd_reg == CMD_RESUME)
            begin
                paused_reg[cmd_btn]  <= 1'b0;
                pressed_reg[cmd_btn] <= 1'b0;
                armed_reg[cmd_btn]   <= 1'b0;
                dur_reg[cmd_btn]     <= '0;
            end
        end
        else if (step_go && !paused_reg[walk_reg])
        begin
            dur_reg[walk_reg]     <= dur_next;
            pressed_reg[walk_reg] <= pressed_next;
            armed_reg[walk_reg]   <= armed_next;
        end
    end

    // walk index and handshake state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
                walk_reg <= '0;
            else if (step_go)
                walk_reg <= walk_reg + BTN_W'(1);

            if (step_go && ev_emit)
                pend_valid_reg <= 1'b1;
            else if (push_flush)
                pend_valid_reg <= 1'b0;

            if (push_step || push_flush)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_cmd_reg     <= cmd_t'(s_tdata[1:0]);
            in_elapsed_reg <= s_tdata[17:2];
            in_levels_reg  <= s_tdata[27:18];
            in_index_reg   <= s_tdata[31:28];
        end
        if (step_go && ev_emit)
        begin
            pend_ev_reg <= ev_code;
            pend_id_reg <= walk_reg;
        end
        if (push_step || push_flush)
        begin
            out_ev_reg   <= pend_ev_reg;
            out_id_reg   <= pend_id_reg;
            out_last_reg <= push_flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, ID_W'(out_id_reg), out_ev_reg};
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== sim/tb_button_click_classifier.sv =====
// tb_button_click_classifier: self-checking bench for the button click classifier
// drives sample, pause and resume words and compares every event word with a local predictor
// depends on bcc_pkg and button_click_classifier

module tb_button_click_classifier;

    import bcc_pkg::*;

    localparam int HANG_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 20;

    // register indexes past the end of the list, writes there must be dropped
    localparam logic [CFGI_W-1:0] REG_SPARE_LO = 3'd5;
    localparam logic [CFGI_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic [LVL_W-1:0] DIR_MASK  = 10'h2AA;
    localparam logic [LVL_W-1:0] DIR_PRESS = DIR_MASK;
    localparam logic [LVL_W-1:0] DIR_FREE  = ~DIR_MASK;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic [LVL_W-1:0] levels;
        logic [MS_W-1:0]  elapsed;
        cmd_t             cmd;
    } in_word_t;

    typedef struct packed {
        event_t          code;
        logic [ID_W-1:0] id;
        logic            last;
    } click_event_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFGI_W-1:0] cfg_index = '0;
    logic [CFGD_W-1:0] cfg_data  = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tlast;

    button_click_classifier DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // shadow registers
    logic [BCNT_W-1:0] btn_count  = '0;
    logic [LVL_W-1:0]  act_mask   = '0;
    logic [MS_W-1:0]   click_min  = 16'd50;
    logic [MS_W-1:0]   long_min   = 16'd1000;
    logic [MS_W-1:0]   dbl_window = 16'd500;

    // per-button state
    logic [MS_W-1:0] hold_ms    [MAX_BUTTONS];
    logic            held       [MAX_BUTTONS];
    logic            dbl_armed  [MAX_BUTTONS];
    logic            frozen     [MAX_BUTTONS];

    in_word_t        pending_words [$];
    click_event_t    events_due    [$];
    logic [LVL_W-1:0] levels_now = '0;
    bit              no_idle     = 1'b0;
    int              errors      = 0;
    int              send_gap    = 0;
    int              stall_left  = 0;
    int              idle_cycles = 0;

    initial
    begin
        for (int i = 0; i < MAX_BUTTONS; i++)
        begin
            hold_ms[i]   = '0;
            held[i]      = 1'b0;
            dbl_armed[i] = 1'b0;
            frozen[i]    = 1'b0;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(30, 80);
    endfunction

    // works out the events one accepted word causes and updates the button state
    task automatic classify_word(input in_word_t w);
        click_event_t hits [$];
        click_event_t ev;
        int           n_use;
        logic [16:0]  sum;
        logic [MS_W-1:0] d;
        logic         emit;
        n_use = (btn_count > MAX_BUTTONS) ? MAX_BUTTONS : int'(btn_count);
        if (w.cmd == CMD_PAUSE || w.cmd == CMD_RESUME)
        begin
            if (int'(w.index) < n_use)
            begin
                if (w.cmd == CMD_PAUSE)
                    frozen[w.index] = 1'b1;
                else
                begin
                    frozen[w.index]    = 1'b0;
                    held[w.index]      = 1'b0;
                    dbl_armed[w.index] = 1'b0;
                    hold_ms[w.index]   = '0;
                end
            end
            return;
        end
        if (w.cmd != CMD_SAMPLE)
            return;
        for (int i = 0; i < n_use; i++)
        begin
            if (frozen[i])
                continue;
            emit = 1'b0;
            d = hold_ms[i];
            if (d != '0)
            begin
                sum = {1'b0, d} + {1'b0, w.elapsed};
                d = (sum < {1'b0, DUR_MAX}) ? sum[MS_W-1:0] : DUR_MAX;
            end
            ev.id   = ID_W'(i);
            ev.last = 1'b0;
            ev.code = EV_PRESSED;
            if (w.levels[i] == act_mask[i])
            begin
                if (!held[i])
                begin
                    dbl_armed[i] = (d != '0) && (d <= dbl_window);
                    held[i] = 1'b1;
                    d = DUR_ONE;
                    emit = 1'b1;
                end
            end
            else if (held[i])
            begin
                if (d >= long_min)
                    ev.code = EV_LONGCLICK;
                else if (d >= click_min)
                    ev.code = dbl_armed[i] ? EV_DBLCLICK : EV_CLICK;
                else
                    ev.code = EV_RELEASED;
                emit = 1'b1;
                held[i] = 1'b0;
                // after a click the gap to the next press is measured
                d = (d >= click_min && d < long_min) ? DUR_ONE : '0;
            end
            hold_ms[i] = d;
            if (emit)
                hits.push_back(ev);
        end
        if (hits.size() > 0)
            hits[hits.size() - 1].last = 1'b1;
        foreach (hits[k])
            events_due.push_back(hits[k]);
    endtask

    task automatic check_event();
        click_event_t want;
        if (events_due.size() == 0)
        begin
            $error("unexpected event word: event_code %0d button_id %0d last %0b",
                   m_tdata[2:0], m_tdata[6:3], m_tlast);
            errors++;
            return;
        end
        want = events_due.pop_front();
        if (m_tdata[2:0] !== want.code)
        begin
            $error("event_code: expected %0d, got %0d", want.code, m_tdata[2:0]);
            errors++;
        end
        if (m_tdata[6:3] !== want.id)
        begin
            $error("button_id: expected %0d, got %0d", want.id, m_tdata[6:3]);
            errors++;
        end
        if (m_tlast !== want.last)
        begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            errors++;
        end
    endtask

    // input side
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
                classify_word(in_word_t'(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (pending_words.size() > 0)
                begin
                    s_tdata  <= pending_words.pop_front();
                    s_tvalid <= 1'b1;
                    if (!no_idle && $urandom_range(0, 3) == 0)
                        send_gap = pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output side
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_event();
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!no_idle && $urandom_range(0, 4) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog: cycles without any word moving
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= HANG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic write_reg(input logic [CFGI_W-1:0] idx, input logic [CFGD_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_BUTTON_COUNT: btn_count  = val[BCNT_W-1:0];
            REG_ACTIVE_MASK:  act_mask   = val[LVL_W-1:0];
            REG_CLICK_MIN:    click_min  = val;
            REG_LONG_MIN:     long_min   = val;
            REG_DBL_WINDOW:   dbl_window = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [BCNT_W-1:0] count, input logic [LVL_W-1:0] mask,
                              input logic [MS_W-1:0] c_min, input logic [MS_W-1:0] l_min,
                              input logic [MS_W-1:0] window);
        write_reg(REG_BUTTON_COUNT, CFGD_W'(count));
        write_reg(REG_ACTIVE_MASK, CFGD_W'(mask));
        write_reg(REG_CLICK_MIN, c_min);
        write_reg(REG_LONG_MIN, l_min);
        write_reg(REG_DBL_WINDOW, window);
    endtask

    task automatic queue_word(input cmd_t cmd, input logic [MS_W-1:0] ms,
                              input logic [LVL_W-1:0] levels, input logic [IDX_W-1:0] idx);
        in_word_t w;
        w.cmd     = cmd;
        w.elapsed = ms;
        w.levels  = levels;
        w.index   = idx;
        pending_words.push_back(w);
    endtask

    // wait for the block to go idle before touching the registers
    task automatic settle();
        while (pending_words.size() > 0 || s_tvalid || events_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // press/release sequences on random buttons, with commands mixed in
    task automatic queue_random(input int n_words);
        int               done;
        int unsigned      r;
        logic [LVL_W-1:0] flips;
        logic [MS_W-1:0]  ms;
        logic [IDX_W-1:0] idx;
        done = 0;
        while (done < n_words)
        begin
            r = $urandom_range(0, 99);
            idx = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 15))
                                              : IDX_W'($urandom_range(0, 9));
            if (r < 7)
                queue_word(CMD_PAUSE, MS_W'($urandom), LVL_W'($urandom), idx);
            else if (r < 13)
                queue_word(CMD_RESUME, MS_W'($urandom), LVL_W'($urandom), idx);
            else if (r < 16)
                queue_word(CMD_NONE, MS_W'($urandom), LVL_W'($urandom), idx);
            else
            begin
                flips = '0;
                for (int b = 0; b < LVL_W; b++)
                    if ($urandom_range(0, 3) == 0)
                        flips[b] = 1'b1;
                levels_now ^= flips;
                r = $urandom_range(0, 99);
                if (r < 40)
                    ms = MS_W'($urandom_range(0, 120));
                else if (r < 65)
                    ms = MS_W'($urandom_range(0, 1200));
                else if (r < 80)
                    ms = MS_W'($urandom);
                else if (r < 90)
                    ms = DUR_MAX;
                else
                    ms = '0;
                queue_word(CMD_SAMPLE, ms, levels_now, IDX_W'($urandom));
            end
            done++;
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // no buttons in use yet: nothing comes out
        queue_word(CMD_SAMPLE, 16'd100, 10'h3FF, 4'd0);
        queue_word(CMD_PAUSE, 16'd0, 10'h000, 4'd0);
        settle();

        set_config(4'd10, DIR_MASK, 16'd50, 16'd1000, 16'd500);
        write_reg(REG_SPARE_LO, 16'hFFFF);
        write_reg(REG_SPARE_HI, 16'hFFFF);

        queue_word(CMD_SAMPLE, 16'd0, DIR_FREE, 4'd0);
        queue_word(CMD_SAMPLE, 16'd5, DIR_PRESS, 4'd0);
        queue_word(CMD_SAMPLE, 16'd10, DIR_FREE, 4'd0);      // too short for a click
        queue_word(CMD_SAMPLE, 16'hFFFF, DIR_PRESS, 4'd0);
        queue_word(CMD_SAMPLE, 16'hFFFF, DIR_FREE, 4'd0);    // duration saturates
        queue_word(CMD_SAMPLE, 16'd0, DIR_PRESS, 4'd0);
        queue_word(CMD_SAMPLE, 16'd100, DIR_FREE, 4'd0);     // click
        queue_word(CMD_SAMPLE, 16'd200, DIR_PRESS, 4'd0);    // inside the window
        queue_word(CMD_SAMPLE, 16'd60, DIR_FREE, 4'd0);      // double click
        queue_word(CMD_SAMPLE, 16'd600, DIR_PRESS, 4'd0);    // window missed
        queue_word(CMD_SAMPLE, 16'd49, DIR_FREE, 4'd0);      // exactly click_min
        queue_word(CMD_SAMPLE, 16'd499, DIR_PRESS, 4'd0);    // exactly at window edge
        queue_word(CMD_SAMPLE, 16'd999, DIR_FREE, 4'd0);     // exactly long_click_min
        queue_word(CMD_PAUSE, 16'd0, 10'h000, 4'd0);
        queue_word(CMD_PAUSE, 16'd0, 10'h000, 4'd9);
        queue_word(CMD_SAMPLE, 16'd7, 10'h0F0, 4'd0);
        queue_word(CMD_PAUSE, 16'd0, 10'h000, 4'd12);        // index out of range
        queue_word(CMD_RESUME, 16'hFFFF, 10'h3FF, 4'd15);
        queue_word(CMD_NONE, 16'hFFFF, 10'h3FF, 4'd15);
        queue_word(CMD_RESUME, 16'd0, 10'h000, 4'd0);
        queue_word(CMD_SAMPLE, 16'hFFFF, DIR_PRESS, 4'd0);
        queue_word(CMD_RESUME, 16'd0, 10'h000, 4'd9);
        queue_word(CMD_SAMPLE, 16'd300, DIR_FREE, 4'd0);
        settle();

        queue_random(45);
        settle();

        // count above maximum, no release too short for a click, no idling
        set_config(4'd15, 10'h3FF, 16'd0, 16'hFFFF, 16'hFFFF);
        no_idle = 1'b1;
        queue_random(35);
        settle();
        no_idle = 1'b0;

        // one button, every release a long click
        set_config(4'd1, 10'h000, 16'hFFFF, 16'd0, 16'd0);
        queue_random(20);
        settle();

        set_config(4'd11, LVL_W'($urandom), 16'd20, 16'd300, 16'd150);
        queue_random(40);
        settle();

        set_config(4'd4, 10'h00F, 16'd50, 16'd1000, 16'd500);
        queue_random(15);
        settle();

        if (events_due.size() != 0)
        begin
            $error("%0d expected event words never arrived", events_due.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== button_click_classifier.f =====
rtl/bcc_pkg.sv
rtl/bcc_ctrl.sv
rtl/bcc_datapath.sv
rtl/button_click_classifier.sv
sim/tb_button_click_classifier.sv
